### sv/clws_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package clws_pkg;

  // Request kinds as they arrive on the opcode field.
  typedef enum logic [2:0] {
    OP_INIT   = 3'd0,
    OP_CMD    = 3'd1,
    OP_DATA   = 3'd2,
    OP_CURSOR = 3'd3,
    OP_GLYPH  = 3'd4
  } opcode_t;

  localparam int unsigned RUN_MAX         = 11;  // longest run of writes (glyph)
  localparam int unsigned RELEASE_MAX     = 10;  // writes released per request
  localparam int unsigned BACKLOG_CAP     = 32;  // backlog that a run may not exceed
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam int unsigned RUN_LEN_W  = 4;  // holds 0..RUN_MAX
  localparam int unsigned BACKLOG_W  = 6;  // holds 0..BACKLOG_CAP + RUN_MAX

  localparam logic [7:0] CMD_FUNCTION_SET = 8'h38;
  localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
  localparam logic [7:0] CMD_CLEAR        = 8'h01;
  localparam logic [7:0] DDRAM_BASE       = 8'd128;
  localparam logic [7:0] LINE1_OFFSET     = 8'h40;
  localparam logic [7:0] CGRAM_BASE       = 8'd64;

  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

  // One classified request, as it waits between front and back.
  typedef struct packed {
    opcode_t     op;
    logic [7:0]  byte_value;
    logic [7:0]  cursor_cmd;
    logic [2:0]  glyph_slot;
    logic [63:0] glyph_rows;
  } run_desc_t;

  // Writes that the back end may now release, granted at each transfer.
  typedef struct packed {
    logic                 valid;
    logic [RUN_LEN_W-1:0] amount;
  } credit_grant_t;

  function automatic logic [RUN_LEN_W-1:0] run_length(input opcode_t op);
    logic [RUN_LEN_W-1:0] len;
    case (op)
      OP_INIT:   len = RUN_LEN_W'(3);
      OP_CMD:    len = RUN_LEN_W'(1);
      OP_DATA:   len = RUN_LEN_W'(1);
      OP_CURSOR: len = RUN_LEN_W'(1);
      OP_GLYPH:  len = RUN_LEN_W'(RUN_MAX);
      default:   len = '0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

### sv/char_lcd_write_sequencer_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake               Payload
// in_       input      in_valid / in_ready     opcode, byte_value, row, column,
//                                              glyph_slot, glyph_rows
// out_      output     out_valid / out_ready   register_select, bus_byte, last_write
//
// At most one bus write leaves per cycle, while the back end holds credit and the
// output is not stalled; a glyph request is eleven writes, init three, command,
// data and cursor move one each, and an unused opcode none (run_length in clws_pkg).
// A request is taken in the cycle it arrives while the request queue has room,
// so the front keeps accepting while the back end or the output is stalled.
// Each request releases at most ten writes of the backlog; held writes go out
// once later requests release them, and a run that would overflow the
// backlog limit of 32 writes is dropped whole.
// Reset (rst_n low, synchronous) empties the queue, the backlog and the credits.

module char_lcd_write_sequencer_top #(
  parameter int unsigned QUEUE_DEPTH = clws_pkg::QUEUE_DEPTH_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [2:0]  in_opcode,
  input  wire  [7:0]  in_byte_value,
  input  wire         in_row,
  input  wire  [5:0]  in_column,
  input  wire  [2:0]  in_glyph_slot,
  input  wire  [63:0] in_glyph_rows,
  output logic        out_valid,
  input  wire         out_ready,
  output logic        out_register_select,
  output logic [7:0]  out_bus_byte,
  output logic        out_last_write
);
  import clws_pkg::*;

  logic          push;
  run_desc_t     push_desc;
  logic          q_full;
  credit_grant_t grant;
  logic          q_pop;
  logic          q_valid;
  run_desc_t     q_desc;

  // The front classifies each request, keeps the backlog account and
  // grants release credits at every transfer.
  clws_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_byte_value (in_byte_value),
    .in_row        (in_row),
    .in_column     (in_column),
    .in_glyph_slot (in_glyph_slot),
    .in_glyph_rows (in_glyph_rows),
    .q_full        (q_full),
    .push          (push),
    .push_desc     (push_desc),
    .grant         (grant)
  );

  // Short queue of classified requests between the two halves.
  clws_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_desc  (q_desc)
  );

  // The back end expands each request into its writes, one per cycle unless
  // out of credit or stalled, into the output register, spending one credit per write.
  clws_back #(
    .DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .grant               (grant),
    .q_valid             (q_valid),
    .q_desc              (q_desc),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_register_select (out_register_select),
    .out_bus_byte        (out_bus_byte),
    .out_last_write      (out_last_write)
  );

endmodule

`default_nettype wire

### sv/clws_front.sv
`timescale 1ns / 1ps
`default_nettype none

module clws_front (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire  [2:0]              in_opcode,
  input  wire  [7:0]              in_byte_value,
  input  wire                     in_row,
  input  wire  [5:0]              in_column,
  input  wire  [2:0]              in_glyph_slot,
  input  wire  [63:0]             in_glyph_rows,
  input  wire                     q_full,
  output logic                    push,
  output clws_pkg::run_desc_t     push_desc,
  output clws_pkg::credit_grant_t grant
);
  import clws_pkg::*;

  logic [BACKLOG_W-1:0] backlog_r, backlog_nxt;
  logic [BACKLOG_W-1:0] sum;
  logic [BACKLOG_W-1:0] held;
  logic [BACKLOG_W-1:0] release_cnt;
  logic [RUN_LEN_W-1:0] len;
  logic                 keep;
  logic                 xfer;
  opcode_t              op;

  assign op       = opcode_t'(in_opcode);
  assign in_ready = !q_full;
  assign xfer     = in_valid && in_ready;

  // The backlog counts writes that have been taken in but not yet released.
  // A run that would push it past its cap is dropped whole.
  always_comb begin
    len         = run_length(op);
    sum         = backlog_r + BACKLOG_W'(len);
    keep        = (len != '0) && (sum <= BACKLOG_W'(BACKLOG_CAP));
    held        = keep ? sum : backlog_r;
    release_cnt = (held < BACKLOG_W'(RELEASE_MAX)) ? held : BACKLOG_W'(RELEASE_MAX);
    backlog_nxt = xfer ? (held - release_cnt) : backlog_r;
  end

  always_comb begin
    push                 = xfer && keep;
    push_desc.op         = op;
    push_desc.byte_value = in_byte_value;
    push_desc.cursor_cmd = DDRAM_BASE + {2'b00, in_column} + (in_row ? LINE1_OFFSET : 8'h00);
    push_desc.glyph_slot = in_glyph_slot;
    push_desc.glyph_rows = in_glyph_rows;
    grant.valid          = xfer;
    grant.amount         = xfer ? release_cnt[RUN_LEN_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      backlog_r <= '0;
    end else begin
      backlog_r <= backlog_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/clws_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module clws_queue #(
  parameter int unsigned DEPTH = clws_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  clws_pkg::run_desc_t push_desc,
  output logic                full,
  input  wire                 pop,
  output logic                pop_valid,
  output clws_pkg::run_desc_t pop_desc
);
  import clws_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  run_desc_t        slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_desc  = slots_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/clws_back.sv
`timescale 1ns / 1ps
`default_nettype none

module clws_back #(
  parameter int unsigned DEPTH = clws_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  clws_pkg::credit_grant_t grant,
  input  wire                     q_valid,
  input  clws_pkg::run_desc_t     q_desc,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic                    out_register_select,
  output logic [7:0]              out_bus_byte,
  output logic                    out_last_write
);
  import clws_pkg::*;

  // Credits never exceed the writes held in the queue, the current run and
  // the output register.
  localparam int unsigned CREDIT_W = $clog2((DEPTH + 2) * RUN_MAX + 1);

  run_desc_t            cur_r, cur_nxt;
  logic                 cur_valid_r, cur_valid_nxt;
  logic [RUN_LEN_W-1:0] idx_r, idx_nxt;
  logic [CREDIT_W-1:0]  credit_r, credit_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 rs_r, rs_nxt;
  logic [7:0]           byte_r, byte_nxt;
  logic                 last_r, last_nxt;
  logic [RUN_LEN_W-1:0] len;
  logic                 is_last;
  logic                 load;
  logic                 w_rs;
  logic [7:0]           w_byte;
  logic [2:0]           row_sel;

  assign out_valid           = out_valid_r;
  assign out_register_select = rs_r;
  assign out_bus_byte        = byte_r;
  assign out_last_write      = last_r;

  // Write number idx_r of the current run.
  always_comb begin
    row_sel = 3'(idx_r - 1'b1);
    w_rs    = RS_CMD;
    w_byte  = cur_r.byte_value;
    case (cur_r.op)
      OP_INIT: begin
        w_byte = (idx_r == '0) ? CMD_FUNCTION_SET :
                 (idx_r == RUN_LEN_W'(1)) ? CMD_DISPLAY_ON : CMD_CLEAR;
      end
      OP_CMD: begin
        w_byte = cur_r.byte_value;
      end
      OP_DATA: begin
        w_rs   = RS_DATA;
        w_byte = cur_r.byte_value;
      end
      OP_CURSOR: begin
        w_byte = cur_r.cursor_cmd;
      end
      OP_GLYPH: begin
        if (idx_r == '0) begin
          w_byte = CGRAM_BASE + {2'b00, cur_r.glyph_slot, 3'b000};
        end else if (idx_r == RUN_LEN_W'(RUN_MAX - 2)) begin
          w_byte = cur_r.cursor_cmd;
        end else if (idx_r == RUN_LEN_W'(RUN_MAX - 1)) begin
          w_rs   = RS_DATA;
          w_byte = {5'b00000, cur_r.glyph_slot};
        end else begin
          w_rs   = RS_DATA;
          w_byte = cur_r.glyph_rows[{row_sel, 3'b000} +: 8];
        end
      end
      default: begin
        w_byte = cur_r.byte_value;
      end
    endcase
  end

  always_comb begin
    len     = run_length(cur_r.op);
    is_last = (idx_r == len - 1'b1);
    load    = cur_valid_r && (credit_r != '0) && (!out_valid_r || out_ready);
    q_pop   = q_valid && (!cur_valid_r || (load && is_last));

    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    if (load) begin
      idx_nxt = idx_r + 1'b1;
      if (is_last) begin
        cur_valid_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      cur_nxt       = q_desc;
      cur_valid_nxt = 1'b1;
      idx_nxt       = '0;
    end

    credit_nxt = credit_r + CREDIT_W'(grant.valid ? grant.amount : '0) - CREDIT_W'(load);

    out_valid_nxt = out_valid_r;
    rs_nxt        = rs_r;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      rs_nxt        = w_rs;
      byte_nxt      = w_byte;
      last_nxt      = is_last;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    rs_r   <= rs_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
      credit_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
      credit_r    <= credit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire
